// File: hw/rtl/fbt_pkg.sv
// Shared constants, types and table functions of the FM bell tone sample generator.
package fbt_pkg;

  // Default values of the top-level parameters.
  localparam int SINE_ADDR_BITS_DEF = 12;
  localparam int EXP_ADDR_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  // Field widths.
  localparam int TIME_W       = 32;
  localparam int FREQ_W       = 24;
  localparam int IN_DATA_W    = TIME_W + FREQ_W;
  localparam int MOD_FREQ_W   = 24;
  localparam int PEAK_INDEX_W = 8;
  localparam int DECAY_RATE_W = 24;
  localparam int PHASE_W      = 32;
  localparam int MAG_W        = 31;
  localparam int AMP_W        = 31;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 2'd2;
  localparam logic [DECAY_RATE_W-1:0] DECAY_RATE_RST = 24'd65536;

  // Fixed-point constants.
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
  // Shifts of 31 or more leave nothing of a Q1.30 amplitude.
  localparam logic [6:0] AMP_SHIFT_MAX = 7'd31;

  // Pipeline depth, the output register included.
  localparam int NUM_STAGES = 11;

  typedef struct packed {
    logic                  in_ready;
    logic                  out_valid;
    logic [NUM_STAGES-1:0] ld;
  } fbt_pipe_t;

  // Series divisors (2n)(2n+1) for the sine and n for the exponential.
  localparam int SIN_TERMS = 12;
  localparam int EXP_TERMS = 20;
  localparam logic [63:0] SIN_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };
  localparam logic [63:0] EXP_DIV [1:20] = '{
    64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
    64'd11, 64'd12, 64'd13, 64'd14, 64'd15, 64'd16, 64'd17, 64'd18, 64'd19, 64'd20
  };

  // Magnitude of sin(2*pi*idx/2^abits) in Q1.30, by an integer Taylor series
  // on the folded first quadrant.
  function automatic logic [MAG_W-1:0] fbt_sine_mag(input int unsigned idx,
                                                    input int unsigned abits);
    logic [63:0] half;
    logic [63:0] quarter;
    logic [63:0] h;
    logic [63:0] x;
    logic [63:0] acc;
    logic [63:0] term;
    int n;
    half    = 64'd1 << (abits - 1);
    quarter = 64'd1 << (abits - 2);
    h = 64'(idx) & (half - 64'd1);
    if (h > quarter) begin
      h = half - h;
    end
    x    = (h * TWO_PI_Q30) >> abits;
    acc  = x;
    term = x;
    for (n = 1; n <= SIN_TERMS; n++) begin
      if (term != 64'd0) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / SIN_DIV[n];
        if ((n & 1) != 0) begin
          acc = (acc >= term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    return acc[MAG_W-1:0];
  endfunction

  // 2^(-idx/2^abits) in Q1.30, formed as e^z/2 with z = (1 - idx/2^abits)*ln2.
  function automatic logic [AMP_W-1:0] fbt_exp_val(input int unsigned idx,
                                                   input int unsigned abits);
    logic [63:0] z;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] half_val;
    int n;
    z    = (((64'd1 << abits) - 64'(idx)) * LN2_Q30) >> abits;
    acc  = ONE_Q30;
    term = ONE_Q30;
    for (n = 1; n <= EXP_TERMS; n++) begin
      if (term != 64'd0) begin
        term = ((term * z) >> 30) / EXP_DIV[n];
        acc  = acc + term;
      end
    end
    half_val = (acc + 64'd1) >> 1;
    return half_val[AMP_W-1:0];
  endfunction

endpackage

// File: hw/rtl/fbt_sine_rom.sv
// Sine table: half-wave magnitude ROM with registered read, sign from the top address bit.
module fbt_sine_rom #(
  parameter int ADDR_BITS = fbt_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ADDR_BITS-1:0]       addr,
  output logic [fbt_pkg::MAG_W-1:0]  mag,
  output logic                       neg
);
  import fbt_pkg::*;

  localparam int DEPTH = 2 ** (ADDR_BITS - 1);

  logic [MAG_W-1:0] rom [DEPTH];
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = fbt_sine_mag(i, ADDR_BITS);
  end

  // The second half-wave repeats the first with the sign flipped.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= rom[addr[ADDR_BITS-2:0]];
      neg_r <= addr[ADDR_BITS-1];
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// File: hw/rtl/fbt_exp_rom.sv
// Base-2 exponent table 2^(-f) in Q1.30 with registered read.
module fbt_exp_rom #(
  parameter int ADDR_BITS = fbt_pkg::EXP_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ADDR_BITS-1:0]       addr,
  output logic [fbt_pkg::AMP_W-1:0]  data
);
  import fbt_pkg::*;

  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [AMP_W-1:0] rom [DEPTH];
  logic [AMP_W-1:0] data_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = fbt_exp_val(i, ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom[addr];
    end
  end

  assign data = data_r;

endmodule

// File: hw/rtl/fbt_pipe_ctrl.sv
// Valid bits and per-stage load enables of the sample pipeline, with bubble collapsing.
module fbt_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output fbt_pkg::fbt_pipe_t pipe
);
  import fbt_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] ld;

  // A stage loads when the output drains or any stage from it onward is empty.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_ld
    assign ld[g] = out_ready | ~(&vld_r[NUM_STAGES-1:g]);
  end

  assign vld_nxt = (ld & {vld_r[NUM_STAGES-2:0], in_valid}) | (~ld & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.in_ready  = ld[0];
  assign pipe.out_valid = vld_r[NUM_STAGES-1];
  assign pipe.ld        = ld;

endmodule

// File: hw/rtl/fm_bell_tone_sample.sv
// FM bell tone sample generator: eleven-stage fixed-point pipeline, top level.
//
//  channel | direction | beat contents
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | time_index, carrier_freq
//  out_    | master    | sample (signed, saturated)
//  cfg_    | slave     | register index, write data (always ready)
//
// One beat is accepted per clock cycle while in_tready is high; its sample passes
// through the stage registers in order and is loaded into the output register.
// Each stage holds the multipliers, table reads or adders of one datapath step,
// as the stage heads below name them.
// Synchronous reset clears the valid bits and loads the register reset values.
// A stalled output holds its beat; stages behind it keep filling empty slots,
// and in_tready falls only when every stage is full.
module fm_bell_tone_sample #(
  parameter int SINE_ADDR_BITS = fbt_pkg::SINE_ADDR_BITS_DEF,
  parameter int EXP_ADDR_BITS  = fbt_pkg::EXP_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = fbt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] time_index, [55:32] carrier_freq
  input  logic [fbt_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [SAMPLE_BITS-1:0] sample, upper bits zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fbt_pkg::*;

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RND_SH = 61 - SAMPLE_BITS;
  localparam int RES_W  = 63 - RND_SH;
  localparam logic [RES_W-1:0] POS_MAX = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RES_W-1:0] NEG_MAX = RES_W'(1 << (SAMPLE_BITS - 1));

  // Configuration registers.
  logic [MOD_FREQ_W-1:0]   mod_freq_r;
  logic [PEAK_INDEX_W-1:0] peak_index_r;
  logic [DECAY_RATE_W-1:0] decay_rate_r;

  fbt_pipe_t pipe;

  logic [TIME_W-1:0] t_in;
  logic [FREQ_W-1:0] fc_in;

  // Stage 1: time products.
  logic [55:0]        x_prod;
  logic [39:0]        s1_x24_r;
  logic [PHASE_W-1:0] s1_pc_r, s1_pc_nxt;
  logic [PHASE_W-1:0] s1_pm_r, s1_pm_nxt;
  // Stage 2: log2(e) scaling, modulator sine.
  logic [60:0]        y_prod;
  logic [6:0]         s2_k_r;
  logic [EXP_ADDR_BITS-1:0] s2_f_r;
  logic               s2_big_r, s2_big_nxt;
  logic [PHASE_W-1:0] s2_pc_r;
  logic [MAG_W-1:0]   sm_mag;
  logic               sm_neg;
  // Stage 3: exponent table.
  logic [AMP_W-1:0]   exp_val;
  logic [4:0]         s3_k_r;
  logic               s3_zero_r, s3_zero_nxt;
  logic [PHASE_W-1:0] s3_pc_r;
  logic [MAG_W-1:0]   s3_sm_mag_r;
  logic               s3_sm_neg_r;
  // Stage 4: envelope.
  logic [AMP_W-1:0]   s4_amp_r, s4_amp_nxt;
  logic [PHASE_W-1:0] s4_pc_r;
  logic [MAG_W-1:0]   s4_sm_mag_r;
  logic               s4_sm_neg_r;
  // Stage 5: modulation index.
  logic [38:0]        idx_prod;
  logic [24:0]        s5_idx_r;
  logic [AMP_W-1:0]   s5_amp_r;
  logic [PHASE_W-1:0] s5_pc_r;
  logic [MAG_W-1:0]   s5_sm_mag_r;
  logic               s5_sm_neg_r;
  // Stage 6: index times modulator sine.
  logic [55:0]        mag_prod;
  logic [25:0]        s6_mag_r;
  logic [AMP_W-1:0]   s6_amp_r;
  logic [PHASE_W-1:0] s6_pc_r;
  logic               s6_sm_neg_r;
  // Stage 7: radians to cycles.
  logic [55:0]        mc_prod;
  logic [PHASE_W-1:0] s7_mc_r;
  logic [AMP_W-1:0]   s7_amp_r;
  logic [PHASE_W-1:0] s7_pc_r;
  logic               s7_sm_neg_r;
  // Stage 8: carrier phase.
  logic [PHASE_W-1:0] s8_phase_r, s8_phase_nxt;
  logic [AMP_W-1:0]   s8_amp_r;
  // Stage 9: carrier sine.
  logic [MAG_W-1:0]   sc_mag;
  logic               sc_neg;
  logic [AMP_W-1:0]   s9_amp_r;
  // Stage 10: envelope times carrier.
  logic [61:0]        s10_p_r, s10_p_nxt;
  logic               s10_neg_r;
  // Stage 11: rounding and saturation.
  logic [62:0]            rnd_sum;
  logic [RES_W-1:0]       res;
  logic [RES_W-1:0]       sat;
  logic [RES_W-1:0]       sgn_v;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_freq_r   <= '0;
      peak_index_r <= '0;
      decay_rate_r <= DECAY_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MOD_FREQ:   mod_freq_r   <= cfg_data[MOD_FREQ_W-1:0];
        CFG_PEAK_INDEX: peak_index_r <= cfg_data[PEAK_INDEX_W-1:0];
        CFG_DECAY_RATE: decay_rate_r <= cfg_data[DECAY_RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- control
  fbt_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .pipe      (pipe)
  );

  assign in_tready  = pipe.in_ready;
  assign out_tvalid = pipe.out_valid;

  // ------------------------------------------------------------- datapath
  assign t_in  = in_tdata[TIME_W-1:0];
  assign fc_in = in_tdata[IN_DATA_W-1:TIME_W];

  always_comb begin
    x_prod    = 56'(t_in) * 56'(decay_rate_r);
    s1_pc_nxt = PHASE_W'(fc_in) * t_in;
    s1_pm_nxt = PHASE_W'(mod_freq_r) * t_in;
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[0]) begin
      s1_x24_r <= x_prod[55:16];
      s1_pc_r  <= s1_pc_nxt;
      s1_pm_r  <= s1_pm_nxt;
    end
  end

  // Beyond 64 time constants the envelope is gone.
  always_comb begin
    y_prod     = 61'(s1_x24_r[29:0]) * 61'(LOG2E_Q30);
    s2_big_nxt = |s1_x24_r[39:30];
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[1]) begin
      s2_k_r   <= y_prod[60:54];
      s2_f_r   <= y_prod[53 -: EXP_ADDR_BITS];
      s2_big_r <= s2_big_nxt;
      s2_pc_r  <= s1_pc_r;
    end
  end

  fbt_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_mod_sine (
    .clk  (clk),
    .en   (pipe.ld[1]),
    .addr (s1_pm_r[PHASE_W-1 -: SINE_ADDR_BITS]),
    .mag  (sm_mag),
    .neg  (sm_neg)
  );

  fbt_exp_rom #(
    .ADDR_BITS (EXP_ADDR_BITS)
  ) u_exp (
    .clk  (clk),
    .en   (pipe.ld[2]),
    .addr (s2_f_r),
    .data (exp_val)
  );

  assign s3_zero_nxt = s2_big_r | (s2_k_r >= AMP_SHIFT_MAX);

  always_ff @(posedge clk) begin
    if (pipe.ld[2]) begin
      s3_k_r      <= s2_k_r[4:0];
      s3_zero_r   <= s3_zero_nxt;
      s3_pc_r     <= s2_pc_r;
      s3_sm_mag_r <= sm_mag;
      s3_sm_neg_r <= sm_neg;
    end
  end

  assign s4_amp_nxt = s3_zero_r ? '0 : (exp_val >> s3_k_r);

  always_ff @(posedge clk) begin
    if (pipe.ld[3]) begin
      s4_amp_r    <= s4_amp_nxt;
      s4_pc_r     <= s3_pc_r;
      s4_sm_mag_r <= s3_sm_mag_r;
      s4_sm_neg_r <= s3_sm_neg_r;
    end
  end

  assign idx_prod = 39'(peak_index_r) * 39'(s4_amp_r);

  always_ff @(posedge clk) begin
    if (pipe.ld[4]) begin
      s5_idx_r    <= idx_prod[38:14];
      s5_amp_r    <= s4_amp_r;
      s5_pc_r     <= s4_pc_r;
      s5_sm_mag_r <= s4_sm_mag_r;
      s5_sm_neg_r <= s4_sm_neg_r;
    end
  end

  assign mag_prod = 56'(s5_idx_r) * 56'(s5_sm_mag_r);

  always_ff @(posedge clk) begin
    if (pipe.ld[5]) begin
      s6_mag_r    <= mag_prod[55:30];
      s6_amp_r    <= s5_amp_r;
      s6_pc_r     <= s5_pc_r;
      s6_sm_neg_r <= s5_sm_neg_r;
    end
  end

  assign mc_prod = 56'(s6_mag_r) * 56'(INV_2PI_Q32);

  always_ff @(posedge clk) begin
    if (pipe.ld[6]) begin
      s7_mc_r     <= mc_prod[47:16];
      s7_amp_r    <= s6_amp_r;
      s7_pc_r     <= s6_pc_r;
      s7_sm_neg_r <= s6_sm_neg_r;
    end
  end

  // The modulation offset carries the sign of the modulator sine; phases wrap.
  assign s8_phase_nxt = s7_sm_neg_r ? (s7_pc_r - s7_mc_r) : (s7_pc_r + s7_mc_r);

  always_ff @(posedge clk) begin
    if (pipe.ld[7]) begin
      s8_phase_r <= s8_phase_nxt;
      s8_amp_r   <= s7_amp_r;
    end
  end

  fbt_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_car_sine (
    .clk  (clk),
    .en   (pipe.ld[8]),
    .addr (s8_phase_r[PHASE_W-1 -: SINE_ADDR_BITS]),
    .mag  (sc_mag),
    .neg  (sc_neg)
  );

  always_ff @(posedge clk) begin
    if (pipe.ld[8]) begin
      s9_amp_r <= s8_amp_r;
    end
  end

  assign s10_p_nxt = 62'(s9_amp_r) * 62'(sc_mag);

  always_ff @(posedge clk) begin
    if (pipe.ld[9]) begin
      s10_p_r   <= s10_p_nxt;
      s10_neg_r <= sc_neg;
    end
  end

  // Round the magnitude half up, clamp it, then apply the sign.
  always_comb begin
    rnd_sum = {1'b0, s10_p_r} + (63'd1 << (RND_SH - 1));
    res     = rnd_sum[62:RND_SH];
    if (s10_neg_r) begin
      sat   = (res > NEG_MAX) ? NEG_MAX : res;
      sgn_v = RES_W'(0) - sat;
    end else begin
      sat   = (res > POS_MAX) ? POS_MAX : res;
      sgn_v = sat;
    end
    sample_nxt = sgn_v[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[10]) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tdata = OUT_W'(sample_r);

endmodule

// File: hw/rtl/fbt_checker.sv
// Port-level assertions of the FM bell tone sample generator and their bind.
module fbt_checker #(
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // Reset empties the pipeline, so no beat is offered right after it.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat offered right after reset");

  // With the output register free or draining, the front stage can always load.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tready || !out_tvalid) |-> in_tready)
    else $error("input stalled while the output side is free");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("stalled output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind fm_bell_tone_sample fbt_checker #(
  .OUT_W (((SAMPLE_BITS + 7) / 8) * 8)
) u_fbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/testbench.sv
// Self-checking testbench for the FM bell tone sample generator.
module testbench;

  localparam int WAVE_BITS   = fbt_pkg::SINE_ADDR_BITS_DEF;
  localparam int POW2_BITS   = fbt_pkg::EXP_ADDR_BITS_DEF;
  localparam int SAMPLE_W    = fbt_pkg::SAMPLE_BITS_DEF;
  localparam int OUT_W       = ((SAMPLE_W + 7) / 8) * 8;
  localparam int ROUND_SHIFT = 61 - SAMPLE_W;
  localparam int DRAIN_CYCLES = fbt_pkg::NUM_STAGES + 4;
  localparam int NOTES_PER_SETTING = 150;
  localparam int NUM_SETTINGS = 9;
  localparam longint TIMEOUT = 64'd15_000_000;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] LOG2E_Q30   = 64'd1549082005;
  localparam logic [63:0] INV_2PI_Q32 = 64'd683565276;
  localparam logic [63:0] FULL_POS    = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  // The index space has one slot that maps to no register.
  localparam logic [fbt_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [fbt_pkg::IN_DATA_W-1:0]    in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [OUT_W-1:0]                 out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [fbt_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [fbt_pkg::CFG_DATA_W-1:0]   cfg_data;

  // Register shadows used by the sample predictor.
  logic [23:0] mod_q;
  logic [7:0]  peak_q;
  logic [23:0] decay_q;

  int          wave_lut [0:(1<<WAVE_BITS)-1];
  logic [31:0] pow2_lut [0:(1<<POW2_BITS)-1];

  logic [SAMPLE_W-1:0] expected_samples [$];
  int fail_count;
  int notes_sent;
  int samples_seen;
  int saturated_seen;
  int settings_used;
  bit src_steady;
  bit sink_steady;
  int sink_run;
  int sink_stall;

  fm_bell_tone_sample #(
    .SINE_ADDR_BITS(WAVE_BITS),
    .EXP_ADDR_BITS (POW2_BITS),
    .SAMPLE_BITS   (SAMPLE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // sin(a) on the first quadrant, a and result in Q.30.
  function automatic logic [63:0] quarter_sine(input logic [63:0] a);
    logic [63:0] acc;
    logic [63:0] term;
    int n;
    acc  = a;
    term = a;
    n    = 1;
    while (n <= 12 && term != 64'd0) begin
      term = (term * a) >> 30;
      term = ((term * a) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
      n++;
    end
    return (acc > Q30_ONE) ? Q30_ONE : acc;
  endfunction

  // e^z for 0 <= z < 1, Q.30.
  function automatic logic [63:0] exp_frac(input logic [63:0] z);
    logic [63:0] acc;
    logic [63:0] term;
    int n;
    acc  = Q30_ONE;
    term = Q30_ONE;
    n    = 1;
    while (n <= 20 && term != 64'd0) begin
      term = ((term * z) >> 30) / 64'(n);
      acc  = acc + term;
      n++;
    end
    return acc;
  endfunction

  task automatic build_luts();
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] z;
    int half;
    half = 1 << (WAVE_BITS - 1);
    for (int i = 0; i < (1 << WAVE_BITS); i++) begin
      h = 64'(i) & 64'(half - 1);
      if (h > 64'(half / 2)) begin
        h = 64'(half) - h;
      end
      s = quarter_sine((h * TWO_PI_Q30) >> WAVE_BITS);
      wave_lut[i] = (i >= half) ? -int'(s) : int'(s);
    end
    // Entry j holds 2^(-j/size), formed as e^z/2 with z = (1 - j/size)*ln2.
    for (int j = 0; j < (1 << POW2_BITS); j++) begin
      z = (64'((1 << POW2_BITS) - j) * LN2_Q30) >> POW2_BITS;
      pow2_lut[j] = 32'((exp_frac(z) + 64'd1) >> 1);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] bell_sample(input logic [31:0] t,
                                                      input logic [23:0] fc);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] amp;
    logic [63:0] mod_idx;
    logic [63:0] mod_mag;
    logic [63:0] sm_mag;
    logic [63:0] sc_mag;
    logic [63:0] r;
    logic [31:0] carrier_ph;
    logic [31:0] mod_ph;
    logic [31:0] offset;
    logic [31:0] ph;
    int sm;
    int sc;
    // Envelope: 2^-(t*rate*log2 e), zero once the decay is long.
    x   = (64'(t) * 64'(decay_q)) >> 16;
    amp = 64'd0;
    if (x < (64'd64 << 24)) begin
      y = (x * LOG2E_Q30) >> 30;
      if ((y >> 24) < 64'd31) begin
        amp = 64'(pow2_lut[y[23 -: POW2_BITS]]) >> (y >> 24);
      end
    end
    carrier_ph = 32'(64'(fc) * 64'(t));
    mod_ph     = 32'(64'(mod_q) * 64'(t));
    sm     = wave_lut[mod_ph >> (32 - WAVE_BITS)];
    sm_mag = (sm < 0) ? 64'(-sm) : 64'(sm);
    mod_idx = (64'(peak_q) * amp) >> 14;
    mod_mag = (mod_idx * sm_mag) >> 30;
    offset  = 32'((mod_mag * INV_2PI_Q32) >> 16);
    ph      = (sm < 0) ? carrier_ph - offset : carrier_ph + offset;
    sc     = wave_lut[ph >> (32 - WAVE_BITS)];
    sc_mag = (sc < 0) ? 64'(-sc) : 64'(sc);
    r = (amp * sc_mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (sc < 0) begin
      if (r > FULL_POS + 64'd1) begin
        r = FULL_POS + 64'd1;
      end
      r = 64'd0 - r;
    end else if (r > FULL_POS) begin
      r = FULL_POS;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic play_note(input logic [31:0] t, input logic [23:0] fc);
    int gap;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {fc, t};
    do begin
      @(posedge clk);
    end while (!in_tready);
    expected_samples.push_back(bell_sample(t, fc));
    notes_sent++;
  endtask

  task automatic write_reg(input logic [fbt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      fbt_pkg::CFG_MOD_FREQ:   mod_q   = value;
      fbt_pkg::CFG_PEAK_INDEX: peak_q  = value[7:0];
      fbt_pkg::CFG_DECAY_RATE: decay_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_voice(input logic [23:0] fm, input logic [23:0] peak,
                           input logic [23:0] rate);
    write_reg(fbt_pkg::CFG_MOD_FREQ, fm);
    write_reg(fbt_pkg::CFG_PEAK_INDEX, peak);
    write_reg(fbt_pkg::CFG_DECAY_RATE, rate);
    settings_used++;
  endtask

  // Stop sending and let every outstanding sample leave the pipeline.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_power_on_defaults();
    settings_used++;
    play_note(32'd0, 24'd0);
    play_note(32'hFFFF_FFFF, 24'hFF_FFFF);
    play_note(32'd1 << 24, 24'd440 << 8);
    play_note(32'd128, 24'd1 << 23);
    wait_drained();
  endtask

  task automatic test_register_handling();
    // Peak index keeps only its low byte of the write data.
    set_voice(24'd512000, 24'hAB_CDEF, 24'h03_0000);
    // A write to the unmapped index must leave the voice untouched.
    write_reg(CFG_UNMAPPED, 24'hFF_FFFF);
    play_note(32'd3 << 22, 24'd880 << 8);
    play_note(32'h0012_3456, 24'h05_5555);
    play_note(32'h00AA_AAAA, 24'h0A_AAAA);
    wait_drained();
    write_reg(fbt_pkg::CFG_PEAK_INDEX, 24'hFF_FF00);
    write_reg(CFG_UNMAPPED, 24'd0);
    play_note(32'h0012_3456, 24'h05_5555);
    play_note(32'h0040_0000, 24'd1000 << 8);
    wait_drained();
  endtask

  task automatic test_decay_corners();
    // No decay: the envelope stays at its full value for any time.
    set_voice(24'hFF_FFFF, 24'd255, 24'd0);
    play_note(32'hFFFF_FFFF, 24'h12_3457);
    play_note(32'h0080_0001, 24'd220 << 8);
    wait_drained();
    // Unit rate: the exponent crosses 31 near t = 21.49 s, the product 64 at 64 s.
    set_voice(24'd700 << 8, 24'd7, 24'd65536);
    play_note(32'd20 << 24, 24'd500 << 8);
    play_note(32'd360_000_000, 24'd500 << 8);
    play_note(32'd361_000_000, 24'd500 << 8);
    play_note((32'd64 << 24) - 32'd1, 24'd500 << 8);
    play_note(32'd64 << 24, 24'd500 << 8);
    wait_drained();
    write_reg(fbt_pkg::CFG_DECAY_RATE, 24'hFF_FFFF);
    play_note(32'd1, 24'hFF_FFFF);
    play_note(32'd300, 24'd300 << 8);
    wait_drained();
  endtask

  task automatic test_full_scale();
    // A quarter and a three-eighths cycle with a flat envelope; the quarter hits the positive rail.
    set_voice(24'd0, 24'd0, 24'd0);
    play_note(32'd128, 24'd1 << 23);
    play_note(32'd128, 24'd3 << 22);
    play_note(32'hFFFF_FFFF, 24'hFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [23:0] fm;
    logic [23:0] peak;
    logic [23:0] rate;
    logic [31:0] t;
    logic [23:0] fc;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      fm   = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 16));
      peak = 24'($urandom_range(0, 255));
      rate = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12));
      case (p)
        1: begin fm = 24'hFF_FFFF; peak = 24'd255; rate = 24'd0; end
        2: begin fm = 24'd0; peak = 24'd0; rate = 24'hFF_FFFF; end
        3: begin peak = 24'd255; rate = 24'd65536; end
        default: ;
      endcase
      set_voice(fm, peak, rate);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < NOTES_PER_SETTING; n++) begin
        // Most times are short enough that the envelope is still audible.
        case ($urandom_range(0, 3))
          0:       t = $urandom();
          default: t = $urandom() >> $urandom_range(4, 31);
        endcase
        fc = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20));
        play_note(t, fc);
      end
      wait_drained();
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Result side: random stalls on the ready line.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      sink_stall = sink_steady ? 0 : idle_len();
      repeat (sink_stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      sink_run = $urandom_range(1, 24);
      repeat (sink_run) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: unexpected beat, actual %0d", $signed(out_tdata[SAMPLE_W-1:0]));
        fail_count++;
      end else begin
        if (out_tdata[SAMPLE_W-1:0] !== expected_samples[0]) begin
          $error("sample: expected %0d, actual %0d", $signed(expected_samples[0]),
                 $signed(out_tdata[SAMPLE_W-1:0]));
          fail_count++;
        end
        void'(expected_samples.pop_front());
        samples_seen++;
        if (out_tdata[SAMPLE_W-1:0] == FULL_POS[SAMPLE_W-1:0] ||
            out_tdata[SAMPLE_W-1:0] == ~FULL_POS[SAMPLE_W-1:0]) begin
          saturated_seen++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("Timeout with %0d samples outstanding", expected_samples.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    fail_count     = 0;
    notes_sent     = 0;
    samples_seen   = 0;
    saturated_seen = 0;
    settings_used  = 0;
    src_steady     = 1'b0;
    sink_steady    = 1'b0;
    mod_q          = 24'd0;
    peak_q         = 8'd0;
    decay_q        = fbt_pkg::DECAY_RATE_RST;
    build_luts();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_on_defaults();
    test_register_handling();
    test_decay_corners();
    test_full_scale();
    test_random_settings();

    $display("Sent %0d notes across %0d voice settings, checked %0d samples.",
             notes_sent, settings_used, samples_seen);
    $display("%0d samples sat on a rail of the output range.", saturated_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
